// ----- rtl/p3fk_pkg.sv -----
// shared types, constants and functions for the planar three-link arm core
package p3fk_pkg;

   // field and register widths
   localparam int ANGLE_W = 10;
   localparam int WRAP_W = 9;
   localparam int LEN_W = 10;
   localparam int BASE_W = 12;
   localparam int COORD_W = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 88;
   localparam int TRIG_FRAC_BITS_DEF = 16;
   localparam int QUARTER_DEG = 90;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINK_ONE = 3'd0,
      CSR_LINK_TWO = 3'd1,
      CSR_LINK_THREE = 3'd2,
      CSR_BASE_X = 3'd3,
      CSR_BASE_Y = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [LEN_W-1:0] LINK_ONE_RST = 10'd120;
   localparam logic [LEN_W-1:0] LINK_TWO_RST = 10'd100;
   localparam logic [LEN_W-1:0] LINK_THREE_RST = 10'd80;
   localparam logic [BASE_W-1:0] BASE_X_RST = 12'd0;
   localparam logic [BASE_W-1:0] BASE_Y_RST = 12'd100;

   // one joint point
   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

   // sine of d degrees (0..90) rounded to frac bits, evaluated at elaboration only
   function automatic logic [31:0] sin_mag(input int d, input int frac);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] mag;
      longint sum;
      logic done;
      x = (64'(d) * 64'd3373259426) / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      done = 1'b0;
      for (int k = 1; k <= 12; k++) begin
         if (!done) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if (term == 64'd0) begin
               done = 1'b1;
            end else if (k % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      mag = (64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
      if (mag > (64'd1 << frac)) begin
         mag = 64'd1 << frac;
      end
      return mag[31:0];
   endfunction

   // clamp a 16-bit coordinate to the field range
   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [15:0] v);
      if (v > 16'sd8191) begin
         return 14'sd8191;
      end else if (v < -16'sd8192) begin
         return -14'sd8192;
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

// ----- rtl/p3fk_link_cell.sv -----
// one link of the arm: trig lookup, length multiply, point update, three stages
module p3fk_link_cell
   import p3fk_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
   parameter int CARRY_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [WRAP_W-1:0]     in_angle,
   input  point_type             in_point,
   input  logic [CARRY_W-1:0]    in_carry,
   input  logic [LEN_W-1:0]      link_len,
   output logic                  out_valid,
   output point_type             out_point,
   output logic [CARRY_W-1:0]    out_carry
);

   localparam int F = TRIG_FRAC_BITS;
   localparam int MAG_W = F + 1;
   localparam int PROD_W = LEN_W + MAG_W;
   localparam int TERM_W = PROD_W + 1;
   localparam int SUM_W = F + 16;

   // quarter-wave sine table
   logic [MAG_W-1:0] mag_table [0:QUARTER_DEG];
   for (genvar g = 0; g <= QUARTER_DEG; g++) begin : g_table
      assign mag_table[g] = MAG_W'(sin_mag(g, F));
   end

   // quadrant folding for sine and cosine
   logic [WRAP_W-1:0] cos_angle;
   logic [6:0] sin_d, cos_d;
   logic sin_neg_in, cos_neg_in;

   always_comb begin
      cos_angle = (in_angle >= 9'd270) ? in_angle - 9'd270 : in_angle + 9'd90;
      if (in_angle <= 9'd90) begin
         sin_d = 7'(in_angle);
         sin_neg_in = 1'b0;
      end else if (in_angle <= 9'd180) begin
         sin_d = 7'(9'd180 - in_angle);
         sin_neg_in = 1'b0;
      end else if (in_angle <= 9'd270) begin
         sin_d = 7'(in_angle - 9'd180);
         sin_neg_in = 1'b1;
      end else begin
         sin_d = 7'(9'd360 - in_angle);
         sin_neg_in = 1'b1;
      end
      if (cos_angle <= 9'd90) begin
         cos_d = 7'(cos_angle);
         cos_neg_in = 1'b0;
      end else if (cos_angle <= 9'd180) begin
         cos_d = 7'(9'd180 - cos_angle);
         cos_neg_in = 1'b0;
      end else if (cos_angle <= 9'd270) begin
         cos_d = 7'(cos_angle - 9'd180);
         cos_neg_in = 1'b1;
      end else begin
         cos_d = 7'(9'd360 - cos_angle);
         cos_neg_in = 1'b1;
      end
   end

   // stage one: trig magnitudes
   logic v1_ff;
   logic [MAG_W-1:0] sin_ff, cos_ff;
   logic sin_neg_ff, cos_neg_ff;
   point_type p1_ff;
   logic [CARRY_W-1:0] c1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= mag_table[sin_d];
         cos_ff <= mag_table[cos_d];
         sin_neg_ff <= sin_neg_in;
         cos_neg_ff <= cos_neg_in;
         p1_ff <= in_point;
         c1_ff <= in_carry;
      end
   end

   // stage two: signed length products
   logic [PROD_W-1:0] sin_prod, cos_prod;
   logic signed [TERM_W-1:0] s_term_in, c_term_in;

   always_comb begin
      sin_prod = PROD_W'(link_len) * PROD_W'(sin_ff);
      cos_prod = PROD_W'(link_len) * PROD_W'(cos_ff);
      s_term_in = sin_neg_ff ? -$signed({1'b0, sin_prod}) : $signed({1'b0, sin_prod});
      c_term_in = cos_neg_ff ? -$signed({1'b0, cos_prod}) : $signed({1'b0, cos_prod});
   end

   logic v2_ff;
   logic signed [TERM_W-1:0] s_term_ff, c_term_ff;
   point_type p2_ff;
   logic [CARRY_W-1:0] c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_term_ff <= s_term_in;
         c_term_ff <= c_term_in;
         p2_ff <= p1_ff;
         c2_ff <= c1_ff;
      end
   end

   // stage three: add to previous point, truncate toward zero, saturate
   logic signed [SUM_W-1:0] x_sum, y_sum, x_adj, y_adj, x_q, y_q;
   point_type p_in;

   always_comb begin
      x_sum = (SUM_W'(p2_ff.x) <<< F) + SUM_W'(c_term_ff);
      y_sum = (SUM_W'(p2_ff.y) <<< F) - SUM_W'(s_term_ff);
      x_adj = x_sum + (x_sum[SUM_W-1] ? SUM_W'((64'd1 << F) - 64'd1) : '0);
      y_adj = y_sum + (y_sum[SUM_W-1] ? SUM_W'((64'd1 << F) - 64'd1) : '0);
      x_q = x_adj >>> F;
      y_q = y_adj >>> F;
      p_in.x = sat_coord(x_q[15:0]);
      p_in.y = sat_coord(y_q[15:0]);
   end

   logic v3_ff;
   point_type p3_ff;
   logic [CARRY_W-1:0] c3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff <= p_in;
         c3_ff <= c2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_point = p3_ff;
   assign out_carry = c3_ff;

endmodule

// ----- rtl/planar_three_link_forward_kinematics_core.sv -----
// top level of the planar three-link arm forward kinematics core
// pipeline: a request transfer passes one angle stage, then three link cells of
//    three stages each, before it reaches the response
// throughput: one item per cycle; the whole pipeline stalls only while rsp_tready is low
// reset: synchronous, clears all valid bits and loads the register defaults
module planar_three_link_forward_kinematics_core
   import p3fk_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // angle_one, angle_two, angle_three, pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // elbow_x, elbow_y, wrist_x, wrist_y, tip_x, tip_y, pad
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration registers
   logic [LEN_W-1:0] len_one_ff, len_two_ff, len_three_ff;
   logic [BASE_W-1:0] base_x_ff, base_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_one_ff <= LINK_ONE_RST;
         len_two_ff <= LINK_TWO_RST;
         len_three_ff <= LINK_THREE_RST;
         base_x_ff <= BASE_X_RST;
         base_y_ff <= BASE_Y_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINK_ONE: len_one_ff <= csr_wdata[LEN_W-1:0];
            CSR_LINK_TWO: len_two_ff <= csr_wdata[LEN_W-1:0];
            CSR_LINK_THREE: len_three_ff <= csr_wdata[LEN_W-1:0];
            CSR_BASE_X: base_x_ff <= csr_wdata;
            CSR_BASE_Y: base_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // global advance: the last cell register doubles as the output register
   logic en;
   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // cumulative angles wrapped into 0..359
   function automatic logic [WRAP_W-1:0] wrap_deg(input logic signed [11:0] t);
      logic [11:0] v;
      v = 12'(t + 12'sd1800);
      if (v >= 12'd2880) v = v - 12'd2880;
      if (v >= 12'd1440) v = v - 12'd1440;
      if (v >= 12'd720) v = v - 12'd720;
      if (v >= 12'd360) v = v - 12'd360;
      return v[WRAP_W-1:0];
   endfunction

   logic signed [11:0] sum1, sum2, sum3;
   always_comb begin
      sum1 = 12'($signed(req_tdata[9:0]));
      sum2 = sum1 + 12'($signed(req_tdata[19:10]));
      sum3 = sum2 + 12'($signed(req_tdata[29:20]));
   end

   logic v0_ff;
   logic [WRAP_W-1:0] t1_ff, t2_ff, t3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= wrap_deg(sum1);
         t2_ff <= wrap_deg(sum2);
         t3_ff <= wrap_deg(sum3);
      end
   end

   // chain of link cells
   localparam int C0_W = 2 * WRAP_W;
   localparam int C1_W = WRAP_W + $bits(point_type);
   localparam int C2_W = 2 * $bits(point_type);

   point_type base_pt, elbow_pt, wrist_pt, tip_pt;
   logic v1, v2, v3;
   logic [C0_W-1:0] c0_out;
   logic [C1_W-1:0] c1_out;
   logic [C2_W-1:0] c2_out;

   assign base_pt.x = COORD_W'($signed({1'b0, base_x_ff}));
   assign base_pt.y = COORD_W'($signed({1'b0, base_y_ff}));

   p3fk_link_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CARRY_W(C0_W)) u_cell_one (
      .clock, .reset, .en,
      .in_valid(v0_ff), .in_angle(t1_ff), .in_point(base_pt),
      .in_carry({t3_ff, t2_ff}), .link_len(len_one_ff),
      .out_valid(v1), .out_point(elbow_pt), .out_carry(c0_out)
   );

   p3fk_link_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CARRY_W(C1_W)) u_cell_two (
      .clock, .reset, .en,
      .in_valid(v1), .in_angle(c0_out[WRAP_W-1:0]), .in_point(elbow_pt),
      .in_carry({c0_out[C0_W-1:WRAP_W], elbow_pt}), .link_len(len_two_ff),
      .out_valid(v2), .out_point(wrist_pt), .out_carry(c1_out)
   );

   p3fk_link_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS), .CARRY_W(C2_W)) u_cell_three (
      .clock, .reset, .en,
      .in_valid(v2), .in_angle(c1_out[C1_W-1:$bits(point_type)]), .in_point(wrist_pt),
      .in_carry({wrist_pt, c1_out[$bits(point_type)-1:0]}), .link_len(len_three_ff),
      .out_valid(v3), .out_point(tip_pt), .out_carry(c2_out)
   );

   // response packing: carry holds wrist (upper) and elbow (lower) as {y, x}
   assign rsp_tvalid = v3;
   assign rsp_tdata = {4'b0, tip_pt.y, tip_pt.x, c2_out};

endmodule

// ----- rtl/p3fk_checker.sv -----
// port-level checks for the arm core, bound to the top level
module p3fk_checker
   import p3fk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // input side never blocked while the output register is free
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("request blocked with free output");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // handshake outputs are always known, and so is the data of a response
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({rsp_tvalid, req_tready}) && (!rsp_tvalid || !$isunknown(rsp_tdata)))
      else $error("unknown value on the response side");

endmodule

bind planar_three_link_forward_kinematics_core p3fk_checker u_p3fk_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

// ----- tb/sv/planar_three_link_forward_kinematics_core_tb.sv -----
// testbench for the planar three-link arm forward kinematics core
`timescale 1ns / 100ps

module planar_three_link_forward_kinematics_core_tb;
   import p3fk_pkg::*;

   localparam int FRAC = TRIG_FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_LAST = '1;

   // six coordinates, elbow_x in the lowest slot
   typedef logic [5:0][COORD_W-1:0] joint_coords_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register shadow copy
   logic [LEN_W-1:0] len_one = LINK_ONE_RST;
   logic [LEN_W-1:0] len_two = LINK_TWO_RST;
   logic [LEN_W-1:0] len_three = LINK_THREE_RST;
   logic [BASE_W-1:0] origin_x = BASE_X_RST;
   logic [BASE_W-1:0] origin_y = BASE_Y_RST;

   longint sine_lut [0:359];
   logic [3*ANGLE_W-1:0] pending_angles [$];
   joint_coords_type expected_coords [$];
   int send_idle_pct = 12;
   int recv_idle_pct = 56;
   int failures = 0;
   int cycle_count = 0;
   string coord_name [6] = '{"elbow_x", "elbow_y", "wrist_x", "wrist_y", "tip_x", "tip_y"};

   planar_three_link_forward_kinematics_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // taylor series sine in q30, rounded to the fraction width, with quadrant sign
   function automatic longint sine_fixed(input int a);
      logic [63:0] rad;
      logic [63:0] rad_sq;
      logic [63:0] term;
      logic [63:0] mag;
      longint acc;
      int d;
      bit neg;
      neg = (a > 180);
      if (a <= 90) d = a;
      else if (a <= 180) d = 180 - a;
      else if (a <= 270) d = a - 180;
      else d = 360 - a;
      rad = (64'(d) * 64'd3373259426) / 64'd180;
      rad_sq = (rad * rad) >> 30;
      term = rad;
      acc = longint'(rad);
      for (int k = 1; k <= 12; k++) begin
         term = ((term * rad_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (term == 0) break;
         acc = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      mag = (64'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
      if (mag > (64'd1 << FRAC)) mag = 64'd1 << FRAC;
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic int wrap_degrees(input int t);
      int r;
      r = t % 360;
      return (r < 0) ? r + 360 : r;
   endfunction

   function automatic longint clamp_coord(input longint v);
      if (v > 8191) return 8191;
      if (v < -8192) return -8192;
      return v;
   endfunction

   // chain the three links from the base point
   function automatic joint_coords_type arm_joint_points(input logic [3*ANGLE_W-1:0] angles);
      joint_coords_type pts;
      longint px;
      longint py;
      longint scale;
      int a1;
      int a2;
      int a3;
      int heading [3];
      longint lens [3];
      a1 = int'($signed(angles[ANGLE_W-1:0]));
      a2 = int'($signed(angles[2*ANGLE_W-1:ANGLE_W]));
      a3 = int'($signed(angles[3*ANGLE_W-1:2*ANGLE_W]));
      heading[0] = wrap_degrees(a1);
      heading[1] = wrap_degrees(a1 + a2);
      heading[2] = wrap_degrees(a1 + a2 + a3);
      lens[0] = len_one;
      lens[1] = len_two;
      lens[2] = len_three;
      scale = longint'(1) << FRAC;
      px = origin_x;
      py = origin_y;
      for (int j = 0; j < 3; j++) begin
         // signed division truncates toward zero
         px = clamp_coord((px * scale + lens[j] * sine_lut[(heading[j] + 90) % 360]) / scale);
         py = clamp_coord((py * scale - lens[j] * sine_lut[heading[j]]) / scale);
         pts[2*j] = px[COORD_W-1:0];
         pts[2*j+1] = py[COORD_W-1:0];
      end
      return pts;
   endfunction

   // register write, shadow follows the masking of the block
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_LINK_ONE: len_one = val[LEN_W-1:0];
         CSR_LINK_TWO: len_two = val[LEN_W-1:0];
         CSR_LINK_THREE: len_three = val[LEN_W-1:0];
         CSR_BASE_X: origin_x = val;
         CSR_BASE_Y: origin_y = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_angles.size() != 0 || req_tvalid || expected_coords.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [ANGLE_W-1:0] rand_angle();
      if ($urandom_range(9, 0) == 0) return ANGLE_W'($urandom);
      return ANGLE_W'($urandom_range(720, 0) - 360);
   endfunction

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++)
         pending_angles.push_back({rand_angle(), rand_angle(), rand_angle()});
   endtask

   task automatic random_config();
      write_reg(CSR_LINK_ONE, CSR_DATA_W'($urandom));
      write_reg(CSR_LINK_TWO, CSR_DATA_W'($urandom));
      write_reg(CSR_LINK_THREE, CSR_DATA_W'($urandom));
      write_reg(CSR_BASE_X, CSR_DATA_W'($urandom));
      write_reg(CSR_BASE_Y, CSR_DATA_W'($urandom));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            expected_coords.push_back(arm_joint_points(req_tdata[3*ANGLE_W-1:0]));
         if (pending_angles.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_tdata <= {2'b00, pending_angles.pop_front()};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_coords.size() == 0) begin
            $error("unexpected response transfer: %h", rsp_tdata);
            failures++;
         end else begin
            joint_coords_type want;
            want = expected_coords.pop_front();
            for (int f = 0; f < 6; f++) begin
               if (rsp_tdata[f*COORD_W +: COORD_W] !== want[f]) begin
                  $error("%s expected %0d actual %0d", coord_name[f], $signed(want[f]),
                     $signed(rsp_tdata[f*COORD_W +: COORD_W]));
                  failures++;
               end
            end
         end
      end
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int directed [][3];
      for (int a = 0; a < 360; a++) sine_lut[a] = sine_fixed(a);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // extremes, quadrant edges and sums that wrap past a full turn
      directed = '{'{0, 0, 0}, '{90, 0, 0}, '{180, 0, 0}, '{270, 0, 0}, '{-90, 0, 0},
         '{360, 0, 0}, '{-360, 0, 0}, '{511, 0, 0}, '{-512, 0, 0}, '{0, 511, 511},
         '{-512, -512, -512}, '{511, 511, 511}, '{360, 360, 360}, '{-360, -360, -360},
         '{45, 45, 45}, '{30, 60, 90}, '{1, 89, 179}, '{-1, -89, -179}, '{359, 1, 0},
         '{200, 200, 200}, '{135, -270, 315}, '{0, 90, -180}};
      foreach (directed[i])
         pending_angles.push_back({ANGLE_W'(directed[i][2]), ANGLE_W'(directed[i][1]),
            ANGLE_W'(directed[i][0])});
      wait_idle();

      // largest lengths and base, upper bits of the link writes get masked
      write_reg(CSR_LINK_ONE, '1);
      write_reg(CSR_LINK_TWO, '1);
      write_reg(CSR_LINK_THREE, '1);
      write_reg(CSR_BASE_X, '1);
      write_reg(CSR_BASE_Y, '1);
      // writes to unused indexes must change nothing
      for (int idx = CSR_BASE_Y + 1; idx <= CSR_INDEX_LAST; idx++)
         write_reg(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
      queue_random(150);
      wait_idle();

      // zero lengths and base, receiver and sender swap idle rates
      send_idle_pct = 56;
      recv_idle_pct = 12;
      write_reg(CSR_LINK_ONE, '0);
      write_reg(CSR_LINK_TWO, '0);
      write_reg(CSR_LINK_THREE, '0);
      write_reg(CSR_BASE_X, '0);
      write_reg(CSR_BASE_Y, '0);
      queue_random(100);
      wait_idle();

      random_config();
      queue_random(150);
      wait_idle();

      // full rate, no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_config();
      queue_random(200);
      wait_idle();
      random_config();
      queue_random(150);
      wait_idle();

      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/p3fk_pkg.sv
rtl/p3fk_link_cell.sv
rtl/planar_three_link_forward_kinematics_core.sv
rtl/p3fk_checker.sv
tb/sv/planar_three_link_forward_kinematics_core_tb.sv
